// ===== rtl/core/gbfp_pkg.sv =====
// Package for the GNSS binary frame parser: framing constants, parser states,
// result record and the navigation message classifier. No dependencies.
`timescale 1ns / 1ps

package gbfp_pkg;

  localparam int PayloadMax = 64;                  // frames of this length or more are dropped
  localparam int AddrW      = $clog2(PayloadMax);  // payload store address width
  localparam int LenW       = 6;                   // width of the reported length and index
  localparam int CfgAddrW   = 8;                   // width of the register index on the config port

  localparam logic [7:0] SyncFirst  = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] ClassNav   = 8'h01;
  localparam logic [7:0] IdPosllh   = 8'h02;
  localparam logic [7:0] IdSol      = 8'h06;
  localparam logic [7:0] IdVelned   = 8'h12;

  typedef enum logic [1:0] {
    NAV_OTHER  = 2'd0,
    NAV_POSLLH = 2'd1,
    NAV_VELNED = 2'd2,
    NAV_SOL    = 2'd3
  } nav_kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_FILTER_CLASS      = 8'd0,
    CFG_FILTER_CLASS_MASK = 8'd1,
    CFG_FILTER_ID         = 8'd2,
    CFG_FILTER_ID_MASK    = 8'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_HUNT    = 4'd0,
    S_SYNC2   = 4'd1,
    S_CLASS   = 4'd2,
    S_ID      = 4'd3,
    S_LEN_LO  = 4'd4,
    S_LEN_HI  = 4'd5,
    S_DATA    = 4'd6,
    S_CK_A    = 4'd7,
    S_CK_B    = 4'd8,
    S_EMIT_RD = 4'd9,
    S_EMIT_WR = 4'd10
  } parse_state_e;

  typedef struct packed {
    logic [7:0]      msg_class;
    logic [7:0]      msg_id;
    logic [LenW-1:0] payload_length;
    logic [1:0]      nav_kind;
    logic            filter_match;
    logic [7:0]      payload_byte;
    logic [LenW-1:0] byte_index;
    logic            last;
  } result_t;

  function automatic logic [1:0] nav_kind_of(input logic [7:0] cls, input logic [7:0] id);
    nav_kind_e k;
    k = NAV_OTHER;
    if (cls == ClassNav) begin
      if (id == IdPosllh)      k = NAV_POSLLH;
      else if (id == IdVelned) k = NAV_VELNED;
      else if (id == IdSol)    k = NAV_SOL;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/gbfp_ifs.sv =====
// Handshake channels of the GNSS binary frame parser: received bytes, results
// and register writes. Depends on gbfp_pkg for field widths.
`timescale 1ns / 1ps

interface gbfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfp_res_if import gbfp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [7:0]      msg_class;
  logic [7:0]      msg_id;
  logic [LenW-1:0] payload_length;
  logic [1:0]      nav_kind;
  logic            filter_match;
  logic [7:0]      payload_byte;
  logic [LenW-1:0] byte_index;
  logic            last;

  modport source (output valid, output msg_class, output msg_id, output payload_length,
                  output nav_kind, output filter_match, output payload_byte,
                  output byte_index, output last, input ready);
  modport sink   (input valid, input msg_class, input msg_id, input payload_length,
                  input nav_kind, input filter_match, input payload_byte,
                  input byte_index, input last, output ready);
endinterface

interface gbfp_cfg_if import gbfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [7:0]          data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/gnss_binary_frame_parser_unit.sv =====
// Top level of the GNSS binary frame parser: sync hunt, header decode,
// payload store, Fletcher check and result run. Depends on gbfp_pkg, gbfp_ifs.
`timescale 1ns / 1ps

// The parser takes one received byte per rx transaction and accepts a byte
// every clock cycle while it parses. It hunts for the sync pair 0xB5 0x62,
// takes class, id and a little-endian length, drops frames with a length of
// 64 or more, and writes the payload into a 64 x 8 single-port store with a
// registered read. After both checksum bytes match, the store is
// read back and one result transaction is produced per payload byte (a single
// zero-valued result for an empty frame), each carrying the header, the
// navigation message kind and the masked filter match. Each result takes a
// store read, then an output register load that waits out any stall on res;
// rx is held off for the whole run since the store port serves the read-back.
// The final result may still wait in the output register while the parser
// already accepts the next frame's bytes. The store has no clearing pass and
// is ready right after reset. Filter registers are written through cfg, which
// is always ready; unknown indexes are ignored.
module gnss_binary_frame_parser_unit import gbfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbfp_rx_if.sink     rx_i,
  gbfp_res_if.source  res_o,
  gbfp_cfg_if.sink    cfg_i
);

  // Filter registers
  logic [7:0] filter_class_q, filter_class_mask_q, filter_id_q, filter_id_mask_q;

  // Parser state and frame header
  parse_state_e   state_q, state_d;
  logic [7:0]     class_q, class_d;
  logic [7:0]     id_q, id_d;
  logic [7:0]     len_q, len_d;       // low length byte; below PayloadMax once accepted
  logic [AddrW-1:0] cnt_q, cnt_d;     // payload write pointer, then read-back pointer
  logic [7:0]     sum_a_q, sum_a_d;
  logic [7:0]     sum_b_q, sum_b_d;

  // Payload store
  logic [7:0]     mem_q [PayloadMax];
  logic [7:0]     rd_data_q;

  // Output register
  logic           res_valid_q, res_valid_d;
  result_t        res_q, res_d;

  // Control strobes
  logic rx_fire, out_free, mem_we, mem_re, res_load, in_ready;
  logic len_bad, data_done, run_last;
  logic [7:0] c;
  logic [7:0] sum_a_add;
  logic [AddrW:0] cnt_inc;

  assign c         = rx_i.rx_byte;
  assign rx_fire   = rx_i.valid && in_ready;
  assign out_free  = !res_valid_q || res_o.ready;
  assign cnt_inc   = {1'b0, cnt_q} + {{AddrW{1'b0}}, 1'b1};
  assign len_bad   = (c != 8'd0) || (len_q >= 8'(PayloadMax));
  assign data_done = ({1'b0, cnt_inc} >= len_q);
  assign run_last  = (len_q == 8'd0) || ({1'b0, cnt_inc} == len_q);
  assign sum_a_add = sum_a_q + c;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_HUNT:    if (rx_fire) state_d = (c == SyncFirst) ? S_SYNC2 : S_HUNT;
      S_SYNC2:   if (rx_fire) state_d = (c == SyncSecond) ? S_CLASS : S_HUNT;
      S_CLASS:   if (rx_fire) state_d = S_ID;
      S_ID:      if (rx_fire) state_d = S_LEN_LO;
      S_LEN_LO:  if (rx_fire) state_d = S_LEN_HI;
      S_LEN_HI: begin
        if (rx_fire) begin
          if (len_bad)              state_d = S_HUNT;
          else if (len_q == 8'd0)   state_d = S_CK_A;
          else                      state_d = S_DATA;
        end
      end
      S_DATA:    if (rx_fire && data_done) state_d = S_CK_A;
      S_CK_A:    if (rx_fire) state_d = (c == sum_a_q) ? S_CK_B : S_HUNT;
      S_CK_B:    if (rx_fire) state_d = (c == sum_b_q) ? S_EMIT_RD : S_HUNT;
      S_EMIT_RD: state_d = S_EMIT_WR;
      S_EMIT_WR: if (out_free) state_d = run_last ? S_HUNT : S_EMIT_RD;
      default:   state_d = S_HUNT;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_ready = 1'b1;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_load = 1'b0;
    unique case (state_q)
      S_DATA:    mem_we = rx_i.valid;
      S_EMIT_RD: begin
        in_ready = 1'b0;
        mem_re   = 1'b1;
      end
      S_EMIT_WR: begin
        in_ready = 1'b0;
        res_load = out_free;
      end
      default:   in_ready = 1'b1;
    endcase
  end

  assign rx_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // Datapath next values
  always_comb begin
    class_d     = class_q;
    id_d        = id_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;

    if (res_valid_q && res_o.ready) res_valid_d = 1'b0;

    if (rx_fire) begin
      case (state_q)
        S_CLASS: begin
          // Restart the checksum on the class byte
          class_d = c;
          sum_a_d = c;
          sum_b_d = c;
        end
        S_ID: begin
          id_d    = c;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_q + sum_a_add;
        end
        S_LEN_LO: begin
          len_d   = c;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_q + sum_a_add;
        end
        S_LEN_HI: begin
          cnt_d = '0;
          if (!len_bad) begin
            sum_a_d = sum_a_add;
            sum_b_d = sum_b_q + sum_a_add;
          end
        end
        S_DATA: begin
          cnt_d   = cnt_inc[AddrW-1:0];
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_q + sum_a_add;
        end
        S_CK_B:  cnt_d = '0;
        default: cnt_d = cnt_q;
      endcase
    end

    if (res_load) begin
      res_d.msg_class      = class_q;
      res_d.msg_id         = id_q;
      res_d.payload_length = len_q[LenW-1:0];
      res_d.nav_kind       = nav_kind_of(class_q, id_q);
      res_d.filter_match   = (((class_q ^ filter_class_q) & filter_class_mask_q) == 8'd0) &&
                             (((id_q ^ filter_id_q) & filter_id_mask_q) == 8'd0);
      res_d.payload_byte   = (len_q == 8'd0) ? 8'd0 : rd_data_q;
      res_d.byte_index     = LenW'(cnt_q);
      res_d.last           = run_last;
      res_valid_d          = 1'b1;
      cnt_d                = cnt_inc[AddrW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_HUNT;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      len_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
    end
  end

  // Header, checksum and result payload
  always_ff @(posedge clk_i) begin
    class_q <= class_d;
    id_q    <= id_d;
    sum_a_q <= sum_a_d;
    sum_b_q <= sum_b_d;
    res_q   <= res_d;
  end

  // Filter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_class_q      <= 8'd0;
      filter_class_mask_q <= 8'd0;
      filter_id_q         <= 8'd0;
      filter_id_mask_q    <= 8'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        CFG_FILTER_CLASS:      filter_class_q      <= cfg_i.data;
        CFG_FILTER_CLASS_MASK: filter_class_mask_q <= cfg_i.data;
        CFG_FILTER_ID:         filter_id_q         <= cfg_i.data;
        CFG_FILTER_ID_MASK:    filter_id_mask_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Payload store: write during the payload, read back during the run
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cnt_q] <= c;
    if (mem_re) rd_data_q <= mem_q[cnt_q];
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.msg_class      = res_q.msg_class;
  assign res_o.msg_id         = res_q.msg_id;
  assign res_o.payload_length = res_q.payload_length;
  assign res_o.nav_kind       = res_q.nav_kind;
  assign res_o.filter_match   = res_q.filter_match;
  assign res_o.payload_byte   = res_q.payload_byte;
  assign res_o.byte_index     = res_q.byte_index;
  assign res_o.last           = res_q.last;

  // A run starts only after a second checksum byte that matched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_RD && $past(state_q) == S_CK_B) |->
      ($past(rx_i.rx_byte) == $past(sum_b_q)))
    else $error("result run started without a checksum match");

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_valid_q) |-> res_o.ready)
    else $error("pending result overwritten");

  // Payload writes stay inside the frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> ({2'b00, cnt_q} < len_q))
    else $error("payload write pointer beyond frame length");

  // Reported index stays inside the reported length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.payload_length == '0 && res_q.byte_index == '0) ||
                    (res_q.byte_index < res_q.payload_length))
    else $error("result index outside payload");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for gnss_binary_frame_parser_unit: byte stream in, payload runs out.
// Depends on gbfp_pkg and the gbfp_rx_if, gbfp_res_if and gbfp_cfg_if channels.
`timescale 1ns / 1ps

module tb;
  import gbfp_pkg::*;

  // Sizing of the run
  localparam int RandomBytes  = 100;     // random stream length in received bytes
  localparam int DrainCycles  = 16;      // quiet cycles after the last result of a phase
  localparam int HoldCycles   = 300;     // long result stall that fills the parser
  localparam int CycleLimit   = 200_000; // give up beyond this many clocks
  localparam int MaxReports   = 40;      // cap on printed mismatch lines

  // Ways a frame can be damaged on purpose
  typedef enum int {
    FAULT_NONE,
    FAULT_CK_A,
    FAULT_CK_B,
    FAULT_CUT
  } frame_fault_e;

  logic clk;
  logic rst_n;

  gbfp_rx_if  rx ();
  gbfp_res_if res ();
  gbfp_cfg_if cfg ();

  gnss_binary_frame_parser_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predicted parser state, kept in step with every accepted rx transaction
  // ---------------------------------------------------------------------------
  parse_state_e parse_at;
  logic [7:0]   hdr_class;
  logic [7:0]   hdr_id;
  logic [15:0]  hdr_len;
  logic [6:0]   data_count;
  logic [7:0]   fl_a;
  logic [7:0]   fl_b;
  logic [7:0]   payload_copy [PayloadMax];

  // Filter registers as last written
  logic [7:0] flt_class;
  logic [7:0] flt_class_mask;
  logic [7:0] flt_id;
  logic [7:0] flt_id_mask;

  result_t results_due [$];   // expected result transactions, oldest first

  int  mismatches;
  int  rx_accepted;
  int  cycle_count;
  bit  steady;                // no random idling on either side while set
  bit  hold_req;              // ask the result side for one long stall
  int  ready_stall;

  function automatic void fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  // Queue one result per payload byte, or a single empty result for length 0.
  function automatic void queue_frame_run();
    result_t   r;
    logic [5:0] n_len;
    int        n_res;
    nav_kind_e kind;
    logic      hit;
    n_len = hdr_len[5:0];
    n_res = (n_len == 0) ? 1 : int'(n_len);
    kind  = NAV_OTHER;
    if (hdr_class == ClassNav) begin
      case (hdr_id)
        IdPosllh: kind = NAV_POSLLH;
        IdVelned: kind = NAV_VELNED;
        IdSol:    kind = NAV_SOL;
        default:  kind = NAV_OTHER;
      endcase
    end
    hit = (((hdr_class ^ flt_class) & flt_class_mask) == 8'h00) &&
          (((hdr_id ^ flt_id) & flt_id_mask) == 8'h00);
    for (int k = 0; k < n_res; k++) begin
      r.msg_class      = hdr_class;
      r.msg_id         = hdr_id;
      r.payload_length = n_len;
      r.nav_kind       = kind;
      r.filter_match   = hit;
      r.payload_byte   = (n_len == 0) ? 8'h00 : payload_copy[k];
      r.byte_index     = (n_len == 0) ? 6'd0 : 6'(k);
      r.last           = (k == n_res - 1);
      results_due.push_back(r);
    end
  endfunction

  // Advance the predicted parser by one received byte.
  function automatic void follow_rx_byte(input logic [7:0] c);
    case (parse_at)
      S_HUNT:  parse_at = (c == SyncFirst) ? S_SYNC2 : S_HUNT;
      S_SYNC2: parse_at = (c == SyncSecond) ? S_CLASS : S_HUNT;
      S_CLASS: begin
        hdr_class = c;
        fl_a = 8'h00;
        fl_b = 8'h00;
        fletcher_add(c);
        parse_at = S_ID;
      end
      S_ID: begin
        hdr_id = c;
        fletcher_add(c);
        parse_at = S_LEN_LO;
      end
      S_LEN_LO: begin
        hdr_len = {8'h00, c};
        fletcher_add(c);
        parse_at = S_LEN_HI;
      end
      S_LEN_HI: begin
        hdr_len[15:8] = c;
        if (hdr_len >= PayloadMax) begin
          parse_at = S_HUNT;   // oversized: drop the frame
        end else begin
          fletcher_add(c);
          data_count = 7'd0;
          parse_at = (hdr_len == 0) ? S_CK_A : S_DATA;
        end
      end
      S_DATA: begin
        if (data_count < PayloadMax) begin
          payload_copy[data_count[5:0]] = c;
          data_count = data_count + 7'd1;
          fletcher_add(c);
          if (data_count >= hdr_len) parse_at = S_CK_A;
        end else begin
          parse_at = S_HUNT;
        end
      end
      S_CK_A: parse_at = (c == fl_a) ? S_CK_B : S_HUNT;
      S_CK_B: begin
        if (c == fl_b) queue_frame_run();
        parse_at = S_HUNT;
      end
      default: parse_at = S_HUNT;
    endcase
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until the parser takes it. Valid stays high on
  // return so that a following byte can go out back to back.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (rx.ready !== 1'b1) @(posedge clk);
    rx_accepted++;
    follow_rx_byte(b);
  endtask

  // One register write transaction; valid is left for the caller to drop.
  task automatic put_reg(input cfg_reg_e idx, input logic [7:0] val);
    cfg.addr  <= idx;
    cfg.data  <= val;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (cfg.ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_FILTER_CLASS:      flt_class      = val;
      CFG_FILTER_CLASS_MASK: flt_class_mask = val;
      CFG_FILTER_ID:         flt_id         = val;
      CFG_FILTER_ID_MASK:    flt_id_mask    = val;
      default: ;
    endcase
  endtask

  // Write the whole filter; call only when settled.
  task automatic set_filters(input logic [7:0] cls, input logic [7:0] cls_mask,
                             input logic [7:0] id, input logic [7:0] id_mask);
    put_reg(CFG_FILTER_CLASS, cls);
    put_reg(CFG_FILTER_CLASS_MASK, cls_mask);
    put_reg(CFG_FILTER_ID, id);
    put_reg(CFG_FILTER_ID_MASK, id_mask);
    cfg.valid <= 1'b0;
  endtask

  // Bring the parser back to hunting, drop rx valid, wait out every pending
  // result and then a few quiet cycles for a last one still in flight.
  task automatic settle();
    while (parse_at != S_HUNT) send_byte(8'($urandom));
    rx.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Build and send one frame: sync, header, payload and checksum. An oversized
  // length sends the header only, since the parser hunts right after it.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input frame_fault_e fault,
                            input bit extremes);
    logic [7:0] body [$];
    logic [7:0] ca;
    logic [7:0] cb;
    int         cut;
    body = '{cls, id, len[7:0], len[15:8]};
    if (len < PayloadMax) begin
      for (int k = 0; k < int'(len); k++)
        body.push_back(extremes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom));
    end
    ca = 8'h00;
    cb = 8'h00;
    foreach (body[k]) begin
      ca = ca + body[k];
      cb = cb + ca;
    end
    if (len < PayloadMax) begin
      if (fault == FAULT_CK_A) ca = ca ^ 8'($urandom_range(1, 255));
      if (fault == FAULT_CK_B) cb = cb ^ 8'($urandom_range(1, 255));
      body.push_back(ca);
      body.push_back(cb);
    end
    cut = (fault == FAULT_CUT) ? $urandom_range(1, body.size() - 1) : body.size();
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    for (int k = 0; k < cut; k++) send_byte(body[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    res.ready <= 1'b0;
    ready_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        ready_stall = HoldCycles;
      end
      if (ready_stall > 0) begin
        res.ready <= 1'b0;
        ready_stall--;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        res.ready <= 1'b0;
        ready_stall = gap_len() - 1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result not expected, expected none, actual class %0h id %0h index %0d",
                   $time, res.msg_class, res.msg_id, res.byte_index);
      end else begin
        want = results_due.pop_front();
        compare_field("msg_class", want.msg_class, res.msg_class);
        compare_field("msg_id", want.msg_id, res.msg_id);
        compare_field("payload_length", want.payload_length, res.payload_length);
        compare_field("nav_kind", want.nav_kind, res.nav_kind);
        compare_field("filter_match", want.filter_match, res.filter_match);
        compare_field("payload_byte", want.payload_byte, res.payload_byte);
        compare_field("byte_index", want.byte_index, res.byte_index);
        compare_field("last", want.last, res.last);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Each navigation message kind, a near miss on id and a near miss on class.
  task automatic test_nav_kinds();
    send_frame(ClassNav, IdPosllh, 16'd4, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdVelned, 16'd1, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdSol, 16'd2, FAULT_NONE, 1'b0);
    send_frame(ClassNav, 8'h07, 16'd3, FAULT_NONE, 1'b0);
    send_frame(8'h02, IdPosllh, 16'd2, FAULT_NONE, 1'b0);
    settle();
  endtask

  // Empty frames go straight to the checksum and give one empty result.
  task automatic test_empty_frame();
    send_frame(ClassNav, IdPosllh, 16'd0, FAULT_NONE, 1'b0);
    send_frame(8'hFF, 8'hFF, 16'd0, FAULT_NONE, 1'b0);
    settle();
  endtask

  // Largest legal payload, then lengths at and beyond the store size.
  task automatic test_length_limits();
    send_frame(8'hFF, 8'h00, 16'd63, FAULT_NONE, 1'b1);
    send_frame(8'h00, 8'hFF, 16'd64, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdSol, 16'h0100, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdSol, 16'hFFFF, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdSol, 16'd5, FAULT_NONE, 1'b0);
    settle();
  endtask

  // A byte other than 0x62 after 0xB5 must not count as a new first sync.
  task automatic test_broken_sync();
    send_byte(SyncFirst);
    send_frame(ClassNav, IdPosllh, 16'd0, FAULT_NONE, 1'b0);
    send_byte(SyncFirst);
    send_byte(8'h00);
    send_frame(ClassNav, IdVelned, 16'd2, FAULT_NONE, 1'b0);
    settle();
  endtask

  // Either checksum byte wrong drops the frame; the next one still gets through.
  task automatic test_bad_checksum();
    send_frame(ClassNav, IdSol, 16'd3, FAULT_CK_A, 1'b0);
    send_frame(ClassNav, IdSol, 16'd3, FAULT_CK_B, 1'b0);
    send_frame(8'h0A, 8'h04, 16'd0, FAULT_CK_B, 1'b0);
    send_frame(ClassNav, IdSol, 16'd3, FAULT_NONE, 1'b0);
    settle();
  endtask

  // Walk the filter through exact, all-ones, partial masks and back to reset.
  task automatic test_filter_settings();
    set_filters(ClassNav, 8'hFF, IdSol, 8'hFF);
    send_frame(ClassNav, IdSol, 16'd1, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdPosllh, 16'd1, FAULT_NONE, 1'b0);
    settle();
    set_filters(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(8'hFF, 8'hFF, 16'd1, FAULT_NONE, 1'b0);
    send_frame(8'hFE, 8'hFF, 16'd0, FAULT_NONE, 1'b0);
    settle();
    set_filters(8'hA5, 8'hF0, 8'h3C, 8'h0F);
    send_frame(8'hAF, 8'hFC, 16'd2, FAULT_NONE, 1'b0);
    send_frame(8'hAF, 8'hFD, 16'd1, FAULT_NONE, 1'b0);
    settle();
    set_filters(8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Stall the result side for a long stretch while frames keep coming, so the
  // output fills and rx backs up.
  task automatic test_backpressure();
    steady   = 1'b1;
    hold_req = 1'b1;
    send_frame(ClassNav, IdPosllh, 16'd20, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdVelned, 16'd20, FAULT_NONE, 1'b0);
    send_frame(8'h33, 8'h44, 16'd0, FAULT_NONE, 1'b0);
    send_frame(ClassNav, IdSol, 16'd12, FAULT_NONE, 1'b0);
    settle();
    steady = 1'b0;
  endtask

  // Random stream: mostly well-formed frames, plus damaged frames, oversized
  // headers and noise. Reprogram the filter now and then between bursts.
  task automatic test_random_stream();
    int         start;
    int         next_cfg;
    int         r;
    logic [7:0] cls;
    logic [7:0] id;
    logic [15:0] len;
    start    = rx_accepted;
    next_cfg = rx_accepted + 35;
    while (rx_accepted - start < RandomBytes) begin
      if (rx_accepted >= next_cfg) begin
        settle();
        set_filters(8'($urandom), ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom),
                    8'($urandom), ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
        steady   = ($urandom_range(0, 99) < 25);
        next_cfg = rx_accepted + 35;
      end

      // Header: navigation messages, filter hits and arbitrary values
      r = $urandom_range(0, 99);
      if (r < 40) begin
        cls = ClassNav;
        case ($urandom_range(0, 3))
          0:       id = IdPosllh;
          1:       id = IdVelned;
          2:       id = IdSol;
          default: id = 8'($urandom);
        endcase
      end else if (r < 65) begin
        cls = flt_class;
        id  = flt_id;
      end else begin
        cls = 8'($urandom);
        id  = 8'($urandom);
      end

      // Mostly short payloads, a few near the limit
      r = $urandom_range(0, 99);
      if (r < 10)      len = 16'd0;
      else if (r < 90) len = 16'($urandom_range(1, 12));
      else if (r < 97) len = 16'($urandom_range(13, 40));
      else             len = 16'($urandom_range(41, 63));

      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(cls, id, len, FAULT_NONE, 1'b0);
      end else if (r < 78) begin
        send_frame(cls, id, len, ($urandom_range(0, 1) == 0) ? FAULT_CK_A : FAULT_CK_B, 1'b0);
      end else if (r < 84) begin
        send_frame(cls, id, len, FAULT_CUT, 1'b0);
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0:       len = 16'd64;
          1:       len = 16'($urandom_range(65, 255));
          default: len = {8'($urandom_range(1, 255)), 8'($urandom)};
        endcase
        send_frame(cls, id, len, FAULT_NONE, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       send_byte(SyncFirst);
            1:       send_byte(SyncSecond);
            default: send_byte(8'($urandom));
          endcase
        end
      end
    end
    steady = 1'b0;
    settle();
  endtask

  initial begin
    // Drive every input to a known value and clear the predicted state
    rst_n      <= 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    cfg.valid  <= 1'b0;
    cfg.addr   <= CFG_FILTER_CLASS;
    cfg.data   <= 8'h00;
    parse_at       = S_HUNT;
    hdr_class      = 8'h00;
    hdr_id         = 8'h00;
    hdr_len        = 16'h0000;
    data_count     = 7'd0;
    fl_a           = 8'h00;
    fl_b           = 8'h00;
    flt_class      = 8'h00;
    flt_class_mask = 8'h00;
    flt_id         = 8'h00;
    flt_id_mask    = 8'h00;
    mismatches     = 0;
    rx_accepted    = 0;
    cycle_count    = 0;
    steady         = 1'b0;
    hold_req       = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_nav_kinds();
    test_empty_frame();
    test_length_limits();
    test_broken_sync();
    test_bad_checksum();
    test_filter_settings();
    test_backpressure();
    test_random_stream();

    settle();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gbfp_pkg.sv
rtl/core/gbfp_ifs.sv
rtl/core/gnss_binary_frame_parser_unit.sv
bench/tb.sv
